>>> src/bsb_pkg.sv
// Package for the B-spline to Bezier point converter.
// Holds widths, the divide-by-three digit step, point kinds and the item structs.
// No dependencies.
`default_nettype none
package bsb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int INDEX_WIDTH = 16;
	localparam int NUM_AXES    = 3;

	// Three weighted sums per axis: a+2b (g), 2b+c (f), b+2c (next g).
	localparam int NUM_SUMS  = 3;
	localparam int NUM_LANES = NUM_SUMS * NUM_AXES;
	localparam int LANE_G    = 0;
	localparam int LANE_F    = 1;
	localparam int LANE_N    = 2;

	// Radix-4 long division by three, split evenly over the divider stages.
	localparam int SUM_WIDTH        = COORD_WIDTH + 2;
	localparam int NUM_DIGITS       = (SUM_WIDTH + 1) / 2;
	localparam int DIV_STAGES       = 3;
	localparam int DIGITS_PER_STAGE = (NUM_DIGITS + DIV_STAGES - 1) / DIV_STAGES;
	localparam int CHUNK_WIDTH      = 2 * DIGITS_PER_STAGE;
	localparam int DVD_WIDTH        = CHUNK_WIDTH * DIV_STAGES;

	// Bias that makes every sum non-negative; a multiple of three, so the
	// quotient only picks up 2^(COORD_WIDTH-1), removed by flipping its top bit.
	localparam logic [DVD_WIDTH-1:0] DIV_OFFSET = DVD_WIDTH'(3) << (COORD_WIDTH - 1);

	localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_WIDTH   = 1;
	localparam int CNT_WIDTH   = 2;

	typedef enum logic [1:0] {
		KIND_E = 2'd0,
		KIND_F = 2'd1,
		KIND_G = 2'd2
	} kind_t;

	typedef struct packed {
		logic                   is_last;
		logic [INDEX_WIDTH-1:0] seg_ef;
		logic [INDEX_WIDTH-1:0] seg_g;
	} bsb_meta_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][DVD_WIDTH-1:0] dvd;
		bsb_meta_t                           meta;
	} bsb_item_t;

	// Divider work word: remaining dividend bits on top, quotient bits shifting in below.
	typedef struct packed {
		logic [NUM_LANES-1:0][DVD_WIDTH-1:0] work;
		logic [NUM_LANES-1:0][1:0]           rem;
		bsb_meta_t                           meta;
	} bsb_div_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][COORD_WIDTH-1:0] pt;
		kind_t                                kind;
		logic [INDEX_WIDTH-1:0]               segment;
		logic                                 run_end;
		logic                                 curve_end;
	} bsb_result_t;

	// Divide {rem_in, bits} by three, one base-4 digit a step.
	function automatic logic [CHUNK_WIDTH+1:0] div3_chunk(input logic [1:0] rem_in,
		input logic [CHUNK_WIDTH-1:0] bits);
		logic [1:0]             r;
		logic [3:0]             v;
		logic [CHUNK_WIDTH-1:0] q;
		r = rem_in;
		q = '0;
		for (int d = DIGITS_PER_STAGE - 1; d >= 0; d--) begin
			v = {r, bits[2*d +: 2]};
			if (v >= 4'd9) begin
				q[2*d +: 2] = 2'd3;
				r = 2'(v - 4'd9);
			end else if (v >= 4'd6) begin
				q[2*d +: 2] = 2'd2;
				r = 2'(v - 4'd6);
			end else if (v >= 4'd3) begin
				q[2*d +: 2] = 2'd1;
				r = 2'(v - 4'd3);
			end else begin
				q[2*d +: 2] = 2'd0;
				r = v[1:0];
			end
		end
		return {r, q};
	endfunction

endpackage
`default_nettype wire

>>> src/bsb_front.sv
// Front end: accepts de Boor points, keeps the window and count, classifies.
// Pushes biased weighted sums for points that yield results. Uses bsb_pkg.
`default_nettype none
module bsb_front import bsb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [COORD_WIDTH-1:0] px,
	input  wire logic [COORD_WIDTH-1:0] py,
	input  wire logic [COORD_WIDTH-1:0] pz,
	input  wire logic                   final_point,
	input  wire logic                   q_full,
	output logic                        push,
	output bsb_item_t                   push_item
);

	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] older_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] newer_q;
	logic [INDEX_WIDTH-1:0]               seen_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cur;
	logic                                 accept;
	logic                                 ge2;
	logic                                 ge3;
	logic [DVD_WIDTH-1:0]                 a_x;
	logic [DVD_WIDTH-1:0]                 b_x;
	logic [DVD_WIDTH-1:0]                 c_x;

	assign cur      = {pz, py, px};
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign ge2      = seen_q >= INDEX_WIDTH'(2);
	assign ge3      = seen_q >= INDEX_WIDTH'(3);
	assign push     = accept && (final_point ? ge3 : ge2);

	always_comb begin
		push_item.meta.is_last = final_point;
		if (seen_q == INDEX_MAX) begin
			push_item.meta.seg_ef = INDEX_MAX;
			push_item.meta.seg_g  = INDEX_MAX;
		end else if (ge2) begin
			push_item.meta.seg_ef = seen_q - INDEX_WIDTH'(2);
			push_item.meta.seg_g  = seen_q - INDEX_WIDTH'(1);
		end else begin
			push_item.meta.seg_ef = '0;
			push_item.meta.seg_g  = '0;
		end
		a_x = '0;
		b_x = '0;
		c_x = '0;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			a_x = {{(DVD_WIDTH-COORD_WIDTH){older_q[ax][COORD_WIDTH-1]}}, older_q[ax]};
			b_x = {{(DVD_WIDTH-COORD_WIDTH){newer_q[ax][COORD_WIDTH-1]}}, newer_q[ax]};
			c_x = {{(DVD_WIDTH-COORD_WIDTH){cur[ax][COORD_WIDTH-1]}}, cur[ax]};
			push_item.dvd[LANE_G*NUM_AXES+ax] = a_x + (b_x << 1) + DIV_OFFSET;
			push_item.dvd[LANE_F*NUM_AXES+ax] = (b_x << 1) + c_x + DIV_OFFSET;
			push_item.dvd[LANE_N*NUM_AXES+ax] = b_x + (c_x << 1) + DIV_OFFSET;
		end
	end

	// Shift the window on every accepted point but the curve's last; clear it at the curve's end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
			seen_q  <= '0;
		end else if (accept) begin
			if (final_point) begin
				older_q <= '0;
				newer_q <= '0;
				seen_q  <= '0;
			end else begin
				older_q <= newer_q;
				newer_q <= cur;
				if (seen_q != INDEX_MAX) begin
					seen_q <= seen_q + INDEX_WIDTH'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> src/bsb_queue.sv
// Two-entry queue between front end and back end.
// Uses bsb_pkg for the item type.
`default_nettype none
module bsb_queue import bsb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire bsb_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output bsb_item_t      head_item
);

	bsb_item_t              entry_q [QUEUE_DEPTH];
	logic [PTR_WIDTH-1:0]   wr_ptr_q;
	logic [PTR_WIDTH-1:0]   rd_ptr_q;
	logic [CNT_WIDTH-1:0]   count_q;
	logic                   do_pop;

	assign full       = count_q == CNT_WIDTH'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_WIDTH'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_WIDTH'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_WIDTH'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_WIDTH'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> src/bsb_div_stage.sv
// One stage of the divide-by-three pipeline: a chunk of base-4 digits per lane.
// Uses bsb_pkg (div3_chunk, bsb_div_t).
`default_nettype none
module bsb_div_stage import bsb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire bsb_div_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output bsb_div_t      out_data
);

	bsb_div_t                 data_s1;
	logic                     valid_s1;
	bsb_div_t                 nxt;
	logic [CHUNK_WIDTH+1:0]   step;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_comb begin
		nxt      = in_data;
		step     = '0;
		for (int l = 0; l < NUM_LANES; l++) begin
			step = div3_chunk(in_data.rem[l],
				in_data.work[l][DVD_WIDTH-1 -: CHUNK_WIDTH]);
			nxt.rem[l]  = step[CHUNK_WIDTH+1 -: 2];
			nxt.work[l] = {in_data.work[l][DVD_WIDTH-CHUNK_WIDTH-1:0],
				step[CHUNK_WIDTH-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> src/bsb_back.sv
// Back end: divider pipeline, junction point, and result serializer with
// the output handshake. Uses bsb_pkg and bsb_div_stage.
`default_nettype none
module bsb_back import bsb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire bsb_item_t head_item,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output bsb_result_t    result
);

	bsb_div_t st_data  [DIV_STAGES+1];
	logic     st_valid [DIV_STAGES+1];
	logic     st_ready [DIV_STAGES+1];

	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] e_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] f_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] g_q;
	bsb_meta_t                            meta_q;
	logic                                 valid_q;
	kind_t                                idx_q;

	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] e_d;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] f_d;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] g_d;
	logic [COORD_WIDTH:0]                 ef_sum;
	logic                                 take;
	logic                                 last_res;
	logic                                 ser_ready;
	kind_t                                idx_nx;

	function automatic logic [NUM_AXES-1:0][COORD_WIDTH-1:0] nxt_g(input bsb_div_t d);
		logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			r[ax] = d.work[LANE_N*NUM_AXES+ax][COORD_WIDTH-1:0]
				^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end
		return r;
	endfunction

	always_comb begin
		st_data[0].work = head_item.dvd;
		st_data[0].rem  = '0;
		st_data[0].meta = head_item.meta;
	end
	assign st_valid[0] = head_valid;
	assign pop         = head_valid && st_ready[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		bsb_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[k]),
			.in_ready  (st_ready[k]),
			.in_data   (st_data[k]),
			.out_valid (st_valid[k+1]),
			.out_ready (st_ready[k+1]),
			.out_data  (st_data[k+1])
		);
	end

	assign st_ready[DIV_STAGES] = ser_ready;

	// Quotients carry a bias of 2^(COORD_WIDTH-1): flip the top bit to drop it.
	always_comb begin
		ef_sum = '0;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			g_d[ax] = st_data[DIV_STAGES].work[LANE_G*NUM_AXES+ax][COORD_WIDTH-1:0]
				^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
			f_d[ax] = st_data[DIV_STAGES].work[LANE_F*NUM_AXES+ax][COORD_WIDTH-1:0]
				^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
			ef_sum  = {g_d[ax][COORD_WIDTH-1], g_d[ax]} + {f_d[ax][COORD_WIDTH-1], f_d[ax]};
			e_d[ax] = ef_sum[COORD_WIDTH:1];
		end
	end

	assign take      = valid_q && !out_stall;
	assign last_res  = meta_q.is_last ? (idx_q == KIND_E) : (idx_q == KIND_G);
	assign ser_ready = !valid_q || (take && last_res);

	always_comb begin
		case (idx_q)
			KIND_E:  idx_nx = KIND_F;
			KIND_F:  idx_nx = KIND_G;
			default: idx_nx = KIND_G;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= KIND_E;
		end else if (ser_ready) begin
			valid_q <= st_valid[DIV_STAGES];
			idx_q   <= KIND_E;
		end else if (take) begin
			idx_q <= idx_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_ready && st_valid[DIV_STAGES]) begin
			e_q    <= e_d;
			f_q    <= f_d;
			g_q    <= nxt_g(st_data[DIV_STAGES]);
			meta_q <= st_data[DIV_STAGES].meta;
		end
	end

	assign out_valid = valid_q;

	always_comb begin
		result.kind      = idx_q;
		result.run_end   = last_res;
		result.curve_end = meta_q.is_last;
		case (idx_q)
			KIND_E: begin
				result.pt      = e_q;
				result.segment = meta_q.seg_ef;
			end
			KIND_F: begin
				result.pt      = f_q;
				result.segment = meta_q.seg_ef;
			end
			default: begin
				result.pt      = g_q;
				result.segment = meta_q.seg_g;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> src/bspline_to_bezier_points_top.sv
// Uniform cubic B-spline to Bezier point converter, top level.
// Path: an accepted point is written to the queue, registered in each divider
// stage, then in the serializer before its first result shows. Throughput is
// bound by the output port: one result per cycle while out_stall is low.
// Reset: arst_n clears the point window, the count and all valid flags.
// Depends on bsb_pkg, bsb_front, bsb_queue, bsb_div_stage and bsb_back.
`default_nettype none
module bspline_to_bezier_points_top import bsb_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input channel: one de Boor point per transfer.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] px,
	input  wire logic signed [COORD_WIDTH-1:0] py,
	input  wire logic signed [COORD_WIDTH-1:0] pz,
	input  wire logic                          final_point,
	// Output channel: one Bezier control point per transfer.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0]      bx,
	output logic signed [COORD_WIDTH-1:0]      by,
	output logic signed [COORD_WIDTH-1:0]      bz,
	output logic [1:0]                         kind,
	output logic [INDEX_WIDTH-1:0]             segment,
	output logic                               run_end,
	output logic                               curve_end
);

	logic        q_full;
	logic        push;
	bsb_item_t   push_item;
	logic        pop;
	logic        head_valid;
	bsb_item_t   head_item;
	bsb_result_t result;

	// Front end: hold the two previous points, classify the new one and
	// form the biased sums a+2b, 2b+c, b+2c per axis. Points that yield no
	// result only advance or clear the window and never enter the queue.
	bsb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.px          (px),
		.py          (py),
		.pz          (pz),
		.final_point (final_point),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// Decouple the two halves so each can stall on its own.
	bsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Back end: three-stage floor division by three, then the junction point
	// e = floor((g+f)/2), then a serializer that emits e, f, g (or e alone at
	// the curve's end) one per transfer and loads the next item on the last.
	bsb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign bx        = result.pt[0];
	assign by        = result.pt[1];
	assign bz        = result.pt[2];
	assign kind      = result.kind;
	assign segment   = result.segment;
	assign run_end   = result.run_end;
	assign curve_end = result.curve_end;

	// The curve's end is a lone junction point that closes its run.
	a_curve_end_is_e: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && curve_end) |-> (run_end && kind == KIND_E))
		else $error("curve end on a result other than a closing e point");

	// A run does not break off: after a result that is not the run's last,
	// the next result is already waiting.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !run_end) |=> out_valid)
		else $error("result run broke off before its end");

	// Inside a run, e is followed by f.
	a_e_then_f: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !run_end && kind == KIND_E) |=>
		(kind == KIND_F))
		else $error("e point not followed by f point");

endmodule
`default_nettype wire

>>> verif/tb_bspline_to_bezier_points_top.sv
// Self-checking testbench for bspline_to_bezier_points_top: streams 3D de Boor points and
// checks each Bezier control point against a scoreboard that predicts e, f and g per point.
// Depends on bsb_pkg and the top level only.
module tb_bspline_to_bezier_points_top;
	import bsb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Random phase length and receiver hold-off.
	localparam int RANDOM_POINTS  = 250;
	localparam int HOLD_OFF_CYCLES = 400;
	// Tail after the last expected point: pipeline latency plus a long receiver stall.
	localparam int DRAIN_CYCLES   = 64;
	// Slowest correct run: some 280 points, each at most a long sender gap and three
	// results behind long receiver stalls, plus the hold-off; the limit allows several
	// times that.
	localparam int CYCLE_LIMIT    = 200_000;

	// Predicts the Bezier points of each accepted de Boor point and checks them in order.
	class bezier_scoreboard;
		coord_t              older_pt[NUM_AXES];
		coord_t              newer_pt[NUM_AXES];
		logic [INDEX_WIDTH-1:0] points_seen;
		bsb_result_t         expected_q[$];
		int                  mismatches;

		function new();
			clear_window();
			mismatches = 0;
		endfunction

		function void clear_window();
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				older_pt[ax] = '0;
				newer_pt[ax] = '0;
			end
			points_seen = '0;
		endfunction

		function longint floor_div(longint num, longint den);
			longint q;
			q = num / den;
			if ((num % den) != 0 && num < 0)
				q -= 1;
			return q;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Append one predicted point at the tail of the expected queue.
		function void expect_point(bsb_result_t r);
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void note_point(coord_t x, coord_t y, coord_t z, logic fin);
			coord_t                 c_pt[NUM_AXES];
			longint                 a, b, c, g, f;
			bsb_result_t            e_pt, f_pt, g_pt;
			logic [INDEX_WIDTH-1:0] seg_ef, seg_g;
			c_pt[0] = x;
			c_pt[1] = y;
			c_pt[2] = z;
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				a = longint'(older_pt[ax]);
				b = longint'(newer_pt[ax]);
				c = longint'(c_pt[ax]);
				g = floor_div(a + 2 * b, 3);
				f = floor_div(2 * b + c, 3);
				e_pt.pt[ax] = COORD_WIDTH'(floor_div(g + f, 2));
				f_pt.pt[ax] = COORD_WIDTH'(f);
				g_pt.pt[ax] = COORD_WIDTH'(floor_div(b + 2 * c, 3));
			end
			// Once the count saturates every index pins at the top.
			if (points_seen == INDEX_MAX) begin
				seg_ef = INDEX_MAX;
				seg_g  = INDEX_MAX;
			end else if (points_seen >= 2) begin
				seg_ef = points_seen - INDEX_WIDTH'(2);
				seg_g  = (seg_ef == INDEX_MAX) ? INDEX_MAX : seg_ef + 1'b1;
			end else begin
				seg_ef = '0;
				seg_g  = '0;
			end
			e_pt.kind      = KIND_E;
			e_pt.segment   = seg_ef;
			e_pt.run_end   = 1'b0;
			e_pt.curve_end = 1'b0;
			f_pt.kind      = KIND_F;
			f_pt.segment   = seg_ef;
			f_pt.run_end   = 1'b0;
			f_pt.curve_end = 1'b0;
			g_pt.kind      = KIND_G;
			g_pt.segment   = seg_g;
			g_pt.run_end   = 1'b1;
			g_pt.curve_end = 1'b0;
			if (fin) begin
				// Curves of three points or fewer yield nothing.
				if (points_seen >= 3) begin
					e_pt.run_end   = 1'b1;
					e_pt.curve_end = 1'b1;
					expect_point(e_pt);
				end
				clear_window();
				return;
			end
			if (points_seen >= 2) begin
				expect_point(e_pt);
				expect_point(f_pt);
				expect_point(g_pt);
			end
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				older_pt[ax] = newer_pt[ax];
				newer_pt[ax] = c_pt[ax];
			end
			if (points_seen != INDEX_MAX)
				points_seen++;
		endfunction

		function void check_result(bsb_result_t got);
			bsb_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected Bezier point x=%0d y=%0d z=%0d kind=%0d seg=%0d",
						$realtime, $signed(got.pt[0]), $signed(got.pt[1]),
						$signed(got.pt[2]), got.kind, got.segment);
				return;
			end
			want = expected_q.pop_front();
			if (got.pt[0] !== want.pt[0] || got.pt[1] !== want.pt[1] ||
				got.pt[2] !== want.pt[2] || got.kind !== want.kind ||
				got.segment !== want.segment || got.run_end !== want.run_end ||
				got.curve_end !== want.curve_end) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: Bezier point mismatch", $realtime);
					$display("  expected x=%0d y=%0d z=%0d kind=%0d seg=%0d run_end=%0b curve_end=%0b",
						$signed(want.pt[0]), $signed(want.pt[1]), $signed(want.pt[2]),
						want.kind, want.segment, want.run_end, want.curve_end);
					$display("  actual   x=%0d y=%0d z=%0d kind=%0d seg=%0d run_end=%0b curve_end=%0b",
						$signed(got.pt[0]), $signed(got.pt[1]), $signed(got.pt[2]),
						got.kind, got.segment, got.run_end, got.curve_end);
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	coord_t                 px = '0;
	coord_t                 py = '0;
	coord_t                 pz = '0;
	logic                   final_point = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	coord_t                 bx, by, bz;
	logic [1:0]             kind;
	logic [INDEX_WIDTH-1:0] segment;
	logic                   run_end;
	logic                   curve_end;

	// Idle controls: set per phase by the stimulus, read by the drivers.
	bit tx_idling = 1'b0;
	bit rx_idling = 1'b0;
	bit rx_hold_req = 1'b0;

	bezier_scoreboard bezier_sb;

	bspline_to_bezier_points_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.px          (px),
		.py          (py),
		.pz          (pz),
		.final_point (final_point),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bx          (bx),
		.by          (by),
		.bz          (bz),
		.kind        (kind),
		.segment     (segment),
		.run_end     (run_end),
		.curve_end   (curve_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gap length for idle stretches: one time in ten a long one, else a short one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Coordinates: full range half of the time, plus extremes and values near zero
	// so that floor rounding of negative sums gets exercised.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0:       return C_MAX;
			1:       return C_MIN;
			2, 3:    return coord_t'($signed($urandom_range(0, 16)) - 8);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Offer one point and hold it until the transfer; then maybe drop valid for a while.
	task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
		input logic fin);
		in_valid    <= 1'b1;
		px          <= x;
		py          <= y;
		pz          <= z;
		final_point <= fin;
		do @(posedge clk); while (in_stall);
		if (tx_idling && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic send_curve(input int len);
		for (int k = 0; k < len; k++)
			send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
	endtask

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		forever begin
			if (rx_hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if (rx_idling && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (gap_len()) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Watch both channels; every transfer is sampled at the edge that makes it.
	always @(posedge clk) begin
		bsb_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				bezier_sb.note_point(px, py, pz, final_point);
			if (out_valid && !out_stall) begin
				got.pt[0]     = bx;
				got.pt[1]     = by;
				got.pt[2]     = bz;
				got.kind      = kind_t'(kind);
				got.segment   = segment;
				got.run_end   = run_end;
				got.curve_end = curve_end;
				bezier_sb.check_result(got);
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int  sent;
		int  len;
		bit  hold_done;
		bezier_sb = new();
		sent      = 0;
		hold_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: curves too short to yield anything (one, two and three points).
		send_point(C_MAX, C_MIN, 0, 1'b1);
		send_point(C_MIN, C_MAX, -1, 1'b0);
		send_point(C_MAX, C_MIN, 1, 1'b1);
		send_point(1, -1, 2, 1'b0);
		send_point(-2, 3, C_MAX, 1'b0);
		send_point(C_MIN, 0, -5, 1'b1);
		// Alternating extremes: largest weighted sums of both signs.
		send_point(C_MAX, C_MIN, 0, 1'b0);
		send_point(C_MIN, C_MAX, -1, 1'b0);
		send_point(C_MAX, C_MIN, 1, 1'b0);
		send_point(C_MIN, C_MAX, -1, 1'b1);
		// Constant extremes: every control point equals the input.
		send_point(C_MAX, C_MIN, C_MAX, 1'b0);
		send_point(C_MAX, C_MIN, C_MAX, 1'b0);
		send_point(C_MAX, C_MIN, C_MAX, 1'b0);
		send_point(C_MAX, C_MIN, C_MAX, 1'b1);
		// Small values of mixed sign: floor rounding of inexact negative quotients.
		send_point(-1, -2, -5, 1'b0);
		send_point(-1, 1, 2, 1'b0);
		send_point(-4, -7, 3, 1'b0);
		send_point(2, -1, -1, 1'b0);
		send_point(0, 0, 0, 1'b1);

		// Random curves: mostly well-formed, some cut short; idling changes per curve.
		while (sent < RANDOM_POINTS) begin
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			if (!hold_done && sent >= RANDOM_POINTS / 2) begin
				// Hold the output off and keep offering points so the block backs up.
				rx_hold_req = 1'b1;
				tx_idling   = 1'b0;
				len         = 12;
				hold_done   = 1'b1;
			end
			send_curve(len);
			sent += len;
		end
		in_valid <= 1'b0;

		// Drain, then give stray results time to show up.
		rx_idling = 1'b1;
		while (bezier_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bezier_sb.mismatches == 0 && bezier_sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
